@@ hw/rtl/pnce_pkg.sv @@
// Package for the pseudo NIC command engine: default sizes, operation,
// register, command and error codes. No dependencies.
package pnce_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 2048;
  localparam int unsigned RING_SLOTS_DEF   = 4;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;
  localparam logic [1:0] OP_PULL  = 2'd3;

  localparam logic [1:0] REG_CMD    = 2'd0;
  localparam logic [1:0] REG_STATUS = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;
  localparam logic [1:0] REG_DATA   = 2'd3;

  localparam logic [15:0] CMD_NOOP     = 16'd0;
  localparam logic [15:0] CMD_API      = 16'd1;
  localparam logic [15:0] CMD_MAC      = 16'd2;
  localparam logic [15:0] CMD_FLUSH    = 16'd3;
  localparam logic [15:0] CMD_TRANSMIT = 16'd4;
  localparam logic [15:0] CMD_RECEIVE  = 16'd5;
  localparam logic [15:0] CMD_QLEN     = 16'd6;
  localparam logic [15:0] CMD_IRQ_MASK = 16'd7;
  localparam logic [15:0] CMD_IRQ_SET  = 16'd8;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_OVERRUN    = 3'd1;
  localparam logic [2:0] ERR_LEN_BIG    = 3'd2;
  localparam logic [2:0] ERR_BAD_REG    = 3'd3;
  localparam logic [2:0] ERR_INCOMPLETE = 3'd4;
  localparam logic [2:0] ERR_DROPPED    = 3'd5;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd6;

  localparam logic CFG_MAC = 1'b0;
  localparam logic CFG_API = 1'b1;

endpackage

@@ hw/rtl/pnce_byte_ram.sv @@
// Byte-wide synchronous RAM, one write port and one registered read port.
// Uses nothing from the package.
module pnce_byte_ram #(
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/pseudo_nic_command_engine.sv @@
// Top level of the pseudo NIC command engine: host registers, receive ring,
// transmit store and command sequencer. Depends on pnce_pkg and pnce_byte_ram.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | op, reg_sel, write_value, rx_data, rx_last
//  out_    | output    | out_valid / out_ready  | read_value, error_code, irq_level, tx_*
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An item passes through accept, execute and deliver, and through a wait state as well
// when it reads a buffer byte through the registered RAM port. Fill commands write one
// byte per cycle, and transmit and receive copy their bytes before delivery: the copy
// walks the buffers one byte per cycle through a single RAM read port.
// Reset is synchronous and active low and clears only control state; buffer
// contents are undefined until written. A finished result sits in the output
// register while the next item is accepted; a stalled result only holds the
// sequencer in its delivery state. Configuration writes are always taken.
module pseudo_nic_command_engine
  import pnce_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int unsigned RING_SLOTS   = RING_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_reg_sel,
  input  logic [15:0] in_write_value,
  input  logic [7:0]  in_rx_data,
  input  logic        in_rx_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_value,
  output logic [2:0]  out_error_code,
  output logic        out_irq_level,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_valid,
  output logic        out_tx_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned LW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned SW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int unsigned QW = $clog2(RING_SLOTS + 1);
  localparam int unsigned DW = SW + QW + 1;
  localparam int unsigned RING_DEPTH = RING_SLOTS * (2 ** AW);
  localparam int unsigned RAW = $clog2(RING_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_RDWAIT = 8'b0000_0100,
    S_TXWAIT = 8'b0000_1000,
    S_FILL   = 8'b0001_0000,
    S_COPY   = 8'b0010_0000,
    S_MASK   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r;

  // Accepted item.
  logic [1:0]  op_r, reg_r;
  logic [15:0] wval_r;
  logic [7:0]  rxd_r;
  logic        rxl_r;

  // Configuration and host-visible state.
  logic [47:0] mac_r;
  logic [15:0] api_r;
  logic [LW-1:0] len_r, cur_r;
  logic          status_r;
  logic [LW-1:0] ring_len_r [RING_SLOTS];
  logic [SW-1:0] wi_r;
  logic [QW-1:0] qc_r;
  logic          irq_en_r, irq_r;
  logic [LW-1:0] tx_cnt_r, tx_ptr_r;
  logic [LW-1:0] rx_fill_r;
  logic          rx_disc_r, rx_trunc_r;

  // Result being built, and the output register.
  logic [15:0] res_rval_r;
  logic [2:0]  res_err_r;
  logic        res_txv_r, res_txl_r;
  logic [7:0]  res_txb_r;
  logic        out_valid_r;
  logic [15:0] out_rval_r;
  logic [2:0]  out_err_r;
  logic        out_irq_r, out_txv_r, out_txl_r;
  logic [7:0]  out_txb_r;

  // Sequencer counters for fills and copies.
  logic [2:0]    fill_idx_r, fill_n_r;
  logic [SW-1:0] copy_slot_r;
  logic [LW-1:0] copy_len_r, copy_rd_r;
  logic          copy_pend_r;
  logic [AW-1:0] copy_wa_r;

  // RAM ports.
  logic          dbuf_we, dbuf_re, txb_we, txb_re, ring_we, ring_re;
  logic [AW-1:0] dbuf_wa, dbuf_ra, txb_wa, txb_ra;
  logic [7:0]    dbuf_wd, dbuf_q, txb_wd, txb_q, ring_wd, ring_q;
  logic [RAW-1:0] ring_wa, ring_ra;

  logic          rx_disc_new, rx_trunc_new;
  logic [LW-1:0] rx_fill_new;
  logic [DW-1:0] old_tmp;
  logic [SW-1:0] old_slot;
  logic [7:0]    fill_byte;
  logic          is_tx_cmd;
  logic          copy_more;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rval_r;
  assign out_error_code = out_err_r;
  assign out_irq_level  = out_irq_r;
  assign out_tx_byte    = out_txb_r;
  assign out_tx_valid   = out_txv_r;
  assign out_tx_last    = out_txl_r;

  assign is_tx_cmd = (wval_r == CMD_TRANSMIT);
  assign copy_more = (copy_rd_r < copy_len_r);

  // A frame whose first byte meets a full ring is dropped whole; bytes past the
  // buffer size are discarded and mark the frame truncated.
  always_comb begin
    rx_disc_new  = rx_disc_r;
    rx_trunc_new = rx_trunc_r;
    rx_fill_new  = rx_fill_r;
    if (rx_fill_r == '0 && !rx_disc_r && !rx_trunc_r && qc_r >= QW'(RING_SLOTS)) begin
      rx_disc_new = 1'b1;
    end
    if (!rx_disc_new) begin
      if (rx_fill_r < LW'(BUFFER_BYTES)) begin
        rx_fill_new = rx_fill_r + 1'b1;
      end else begin
        rx_trunc_new = 1'b1;
      end
    end
  end

  // Oldest queued slot, the write index stepped back by the queue count.
  always_comb begin
    old_tmp = DW'(wi_r) + DW'(RING_SLOTS) - DW'(qc_r);
    if (old_tmp >= DW'(RING_SLOTS)) begin
      old_tmp = old_tmp - DW'(RING_SLOTS);
    end
    old_slot = SW'(old_tmp);
  end

  always_comb begin
    case (wval_r)
      CMD_API: fill_byte = (fill_idx_r == 3'd0) ? api_r[7:0] : api_r[15:8];
      CMD_MAC: fill_byte = mac_r[{fill_idx_r, 3'b000} +: 8];
      default: fill_byte = (fill_idx_r == 3'd0) ? 8'(qc_r) : 8'd0;
    endcase
  end

  always_comb begin
    dbuf_we = 1'b0;
    dbuf_wa = cur_r[AW-1:0];
    dbuf_wd = wval_r[7:0];
    dbuf_re = 1'b0;
    dbuf_ra = cur_r[AW-1:0];
    txb_we  = 1'b0;
    txb_wa  = copy_wa_r;
    txb_wd  = dbuf_q;
    txb_re  = 1'b0;
    txb_ra  = tx_ptr_r[AW-1:0];
    ring_we = 1'b0;
    ring_wa = RAW'({wi_r, rx_fill_r[AW-1:0]});
    ring_wd = rxd_r;
    ring_re = 1'b0;
    ring_ra = RAW'({copy_slot_r, copy_rd_r[AW-1:0]});
    unique case (state_r)
      S_EXEC: begin
        case (op_r)
          OP_READ: dbuf_re = (reg_r == REG_DATA) && (cur_r < len_r);
          OP_WRITE: begin
            dbuf_we = (reg_r == REG_DATA) && (cur_r < len_r);
            if (reg_r == REG_CMD && wval_r == CMD_IRQ_MASK) begin
              dbuf_re = 1'b1;
              dbuf_ra = '0;
            end
          end
          OP_RX: ring_we = !rx_disc_new && (rx_fill_r < LW'(BUFFER_BYTES));
          default: txb_re = (tx_ptr_r < tx_cnt_r);
        endcase
      end
      S_FILL: begin
        dbuf_we = 1'b1;
        dbuf_wa = AW'(fill_idx_r);
        dbuf_wd = fill_byte;
      end
      S_COPY: begin
        if (is_tx_cmd) begin
          dbuf_re = copy_more;
          dbuf_ra = copy_rd_r[AW-1:0];
          txb_we  = copy_pend_r;
        end else begin
          ring_re = copy_more;
          dbuf_we = copy_pend_r;
          dbuf_wa = copy_wa_r;
          dbuf_wd = ring_q;
        end
      end
      default: ;
    endcase
  end

  pnce_byte_ram #(.DEPTH(BUFFER_BYTES)) u_data_ram (
    .clk(clk), .we(dbuf_we), .waddr(dbuf_wa), .wdata(dbuf_wd),
    .re(dbuf_re), .raddr(dbuf_ra), .rdata(dbuf_q)
  );

  pnce_byte_ram #(.DEPTH(BUFFER_BYTES)) u_tx_ram (
    .clk(clk), .we(txb_we), .waddr(txb_wa), .wdata(txb_wd),
    .re(txb_re), .raddr(txb_ra), .rdata(txb_q)
  );

  pnce_byte_ram #(.DEPTH(RING_DEPTH)) u_ring_ram (
    .clk(clk), .we(ring_we), .waddr(ring_wa), .wdata(ring_wd),
    .re(ring_re), .raddr(ring_ra), .rdata(ring_q)
  );

  // Ring lengths and payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r   <= in_op;
      reg_r  <= in_reg_sel;
      wval_r <= in_write_value;
      rxd_r  <= in_rx_data;
      rxl_r  <= in_rx_last;
    end
    if (state_r == S_EXEC && op_r == OP_RX && rxl_r && !rx_disc_new) begin
      ring_len_r[wi_r] <= rx_fill_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mac_r       <= '0;
      api_r       <= '0;
      len_r       <= '0;
      cur_r       <= '0;
      status_r    <= 1'b0;
      wi_r        <= '0;
      qc_r        <= '0;
      irq_en_r    <= 1'b0;
      irq_r       <= 1'b0;
      tx_cnt_r    <= '0;
      tx_ptr_r    <= '0;
      rx_fill_r   <= '0;
      rx_disc_r   <= 1'b0;
      rx_trunc_r  <= 1'b0;
      out_valid_r <= 1'b0;
      copy_pend_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_MAC) begin
          mac_r <= cfg_data;
        end else begin
          api_r <= cfg_data[15:0];
        end
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          res_rval_r <= '0;
          res_err_r  <= ERR_NONE;
          res_txb_r  <= '0;
          res_txv_r  <= 1'b0;
          res_txl_r  <= 1'b0;
          state_r    <= S_DONE;
          case (op_r)
            OP_READ: begin
              unique case (reg_r)
                REG_STATUS: res_rval_r <= status_r ? 16'hFFFF : 16'h0000;
                REG_LENGTH: res_rval_r <= 16'(len_r);
                REG_DATA: begin
                  if (cur_r < len_r) begin
                    cur_r   <= cur_r + 1'b1;
                    state_r <= S_RDWAIT;
                  end else begin
                    res_err_r <= ERR_OVERRUN;
                  end
                end
                default: res_err_r <= ERR_BAD_REG;
              endcase
            end

            OP_WRITE: begin
              unique case (reg_r)
                REG_CMD: begin
                  // Every command ends with the status, a new length and a
                  // zero cursor; byte-producing commands then write the buffer.
                  if (len_r != cur_r) begin
                    res_err_r <= ERR_INCOMPLETE;
                  end
                  status_r   <= 1'b0;
                  len_r      <= '0;
                  cur_r      <= '0;
                  fill_idx_r <= '0;
                  unique case (wval_r)
                    CMD_NOOP: ;
                    CMD_API: begin
                      len_r    <= LW'(2);
                      fill_n_r <= 3'd2;
                      state_r  <= S_FILL;
                    end
                    CMD_MAC: begin
                      len_r    <= LW'(6);
                      fill_n_r <= 3'd6;
                      state_r  <= S_FILL;
                    end
                    CMD_QLEN: begin
                      len_r    <= LW'(2);
                      fill_n_r <= 3'd2;
                      state_r  <= S_FILL;
                    end
                    CMD_FLUSH: qc_r <= '0;
                    CMD_TRANSMIT: begin
                      tx_cnt_r    <= len_r;
                      tx_ptr_r    <= '0;
                      copy_len_r  <= len_r;
                      copy_rd_r   <= '0;
                      copy_pend_r <= 1'b0;
                      state_r     <= S_COPY;
                    end
                    CMD_RECEIVE: begin
                      copy_rd_r   <= '0;
                      copy_pend_r <= 1'b0;
                      copy_slot_r <= old_slot;
                      if (qc_r != '0) begin
                        len_r      <= ring_len_r[old_slot];
                        copy_len_r <= ring_len_r[old_slot];
                        qc_r       <= qc_r - 1'b1;
                        if (qc_r == QW'(1)) begin
                          irq_r <= 1'b0;
                        end
                      end else begin
                        copy_len_r <= '0;
                        irq_r      <= 1'b0;
                      end
                      state_r <= S_COPY;
                    end
                    CMD_IRQ_MASK: state_r <= S_MASK;
                    CMD_IRQ_SET:  irq_r   <= 1'b1;
                    default:      status_r <= 1'b1;
                  endcase
                end
                REG_LENGTH: begin
                  if (wval_r > 16'(BUFFER_BYTES)) begin
                    res_err_r <= ERR_LEN_BIG;
                  end else begin
                    len_r <= LW'(wval_r);
                    cur_r <= '0;
                  end
                end
                REG_DATA: begin
                  if (cur_r < len_r) begin
                    cur_r <= cur_r + 1'b1;
                  end else begin
                    res_err_r <= ERR_OVERRUN;
                  end
                end
                default: res_err_r <= ERR_BAD_REG;
              endcase
            end

            OP_RX: begin
              if (rxl_r) begin
                if (rx_disc_new) begin
                  res_err_r <= ERR_DROPPED;
                end else begin
                  wi_r <= (wi_r == SW'(RING_SLOTS - 1)) ? '0 : wi_r + 1'b1;
                  qc_r <= qc_r + 1'b1;
                  if (irq_en_r) begin
                    irq_r <= 1'b1;
                  end
                  if (rx_trunc_new) begin
                    res_err_r <= ERR_TRUNCATED;
                  end
                end
                rx_fill_r  <= '0;
                rx_disc_r  <= 1'b0;
                rx_trunc_r <= 1'b0;
              end else begin
                rx_fill_r  <= rx_fill_new;
                rx_disc_r  <= rx_disc_new;
                rx_trunc_r <= rx_trunc_new;
              end
            end

            default: begin
              if (tx_ptr_r < tx_cnt_r) begin
                res_txv_r <= 1'b1;
                res_txl_r <= (tx_ptr_r + 1'b1 == tx_cnt_r);
                tx_ptr_r  <= tx_ptr_r + 1'b1;
                state_r   <= S_TXWAIT;
              end
            end
          endcase
        end

        S_RDWAIT: begin
          res_rval_r <= {8'd0, dbuf_q};
          state_r    <= S_DONE;
        end

        S_TXWAIT: begin
          res_txb_r <= txb_q;
          state_r   <= S_DONE;
        end

        S_FILL: begin
          fill_idx_r <= fill_idx_r + 1'b1;
          if (fill_idx_r + 1'b1 == fill_n_r) begin
            state_r <= S_DONE;
          end
        end

        S_COPY: begin
          // Each byte is written in the cycle after its read.
          if (copy_more) begin
            copy_rd_r   <= copy_rd_r + 1'b1;
            copy_wa_r   <= copy_rd_r[AW-1:0];
            copy_pend_r <= 1'b1;
          end else begin
            copy_pend_r <= 1'b0;
            if (!copy_pend_r) begin
              state_r <= S_DONE;
            end
          end
        end

        S_MASK: begin
          irq_en_r <= (dbuf_q != 8'd0);
          irq_r    <= (dbuf_q != 8'd0) && (qc_r != '0);
          state_r  <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_rval_r  <= res_rval_r;
            out_err_r   <= res_err_r;
            out_irq_r   <= irq_r;
            out_txb_r   <= res_txb_r;
            out_txv_r   <= res_txv_r;
            out_txl_r   <= res_txl_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
